[sv/mctp_pkg.sv]
// Shared types, codes and constants of the multi-channel tick PWM unit.
package mctp_pkg;

	// Default build values
	localparam int CHANNELS_DEF  = 8;
	localparam int TICK_RATE_DEF = 1000;

	// Field and datapath widths
	localparam int LEVELS_W = 8;
	localparam int LEN_W    = 16;
	localparam int TICK_W   = 32;
	localparam int DIV_W    = 23;
	localparam int DVS_W    = 16;
	localparam int DUTY_MAX = 100;

	// Operation codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_ALLOCATE = 3'd1;
	localparam logic [2:0] OP_RELEASE  = 3'd2;
	localparam logic [2:0] OP_START    = 3'd3;
	localparam logic [2:0] OP_STOP     = 3'd4;

	// Slot code returned when nothing was granted
	localparam logic signed [3:0] NO_SLOT = -4'sd1;

	// Command word
	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  channel;
		logic [15:0] frequency;
		logic [6:0]  duty_percent;
		logic        pin_level;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [7:0]        pin_levels;
		logic signed [3:0] allocated_slot;
		logic              accepted;
	} out_word_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic tick_inc;
		logic walk_step;
		logic alloc_step;
		logic rel_do;
		logic stop_do;
		logic div1_go;
		logic div1_take;
		logic div2_go;
		logic commit;
		logic finish;
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic op_tick;
		logic op_alloc;
		logic op_rel;
		logic op_start;
		logic op_stop;
		logic start_ok;
		logic walk_last;
		logic alloc_free;
		logic alloc_last;
		logic div_done;
	} sts_t;

endpackage

[sv/mctp_div.sv]
// Restoring divider, one quotient bit per cycle.
module mctp_div
	import mctp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;
	logic             last;

	// Trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};
	assign last  = cnt_q == CNT_W'(DIV_W - 1);

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Shift in quotient bits, keep the remainder
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/mctp_dp.sv]
// Datapath: channel state, tick counter, phase timing and period arithmetic.
module mctp_dp
	import mctp_pkg::*;
#(
	parameter int CHANNELS     = CHANNELS_DEF,
	parameter int TICK_RATE_HZ = TICK_RATE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  cmd,
	input  ctl_t      ctl,
	output sts_t      sts,
	output logic      done,
	output out_word_t rsp
);

	// Only the first eight slots can be addressed, so only they can run
	localparam int NSTORE    = (CHANNELS < LEVELS_W) ? CHANNELS : LEVELS_W;
	localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SIDX_W    = (NSTORE > 1) ? $clog2(NSTORE) : 1;
	localparam int HALF_RATE = TICK_RATE_HZ / 2;

	// Divide by 100 as a quarter, then times the reciprocal of 25
	localparam int               DUTY_W   = 7;
	localparam int               PROD_W   = LEN_W + DUTY_W;
	localparam int               RECIP_W  = 22;
	localparam int               RECIP_SH = 26;
	localparam int               RPROD_W  = PROD_W - 2 + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

	in_word_t            cmd_q;
	logic [TICK_W-1:0]   tick_q;
	logic [CHANNELS-1:0] in_use_q;
	logic [NSTORE-1:0]   run_q;
	logic [NSTORE-1:0]   lvl_q;
	logic [LEN_W-1:0]    hi_len_q [NSTORE];
	logic [LEN_W-1:0]    lo_len_q [NSTORE];
	logic [TICK_W-1:0]   phase_q  [NSTORE];
	logic [IDX_W-1:0]    idx_q;
	logic [LEN_W-1:0]    per_q;
	logic                ok_q;
	logic signed [3:0]   slot_q;
	logic                done_q;
	out_word_t           rsp_q;
	logic                mv_s1;
	logic                mv_s2;
	logic                mv_s3;
	logic [PROD_W-1:0]   prod_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic [LEN_W-1:0]    hi_s2;
	logic [LEN_W-1:0]    hi_s3;
	logic [LEN_W-1:0]    lo_s3;

	logic [IDX_W+2:0]    ch_ext;
	logic [SIDX_W+2:0]   ch_sext;
	logic [IDX_W-1:0]    ch_idx;
	logic [SIDX_W-1:0]   ch_s;
	logic [SIDX_W-1:0]   ws;
	logic [IDX_W+3:0]    slot_ext;
	logic                in_range;
	logic [TICK_W-1:0]   elapsed;
	logic [LEN_W-1:0]    len_sel;
	logic                toggle;
	logic                div_go;
	logic                div_done;
	logic [DIV_W-1:0]    div_dividend;
	logic [DVS_W-1:0]    div_divisor;
	logic [DIV_W-1:0]    div_quo;
	logic [LEN_W-1:0]    per_new;
	logic [RPROD_W-1:0]  recip_prod;
	logic [PROD_W-1:0]   prod_back;
	logic                rem_nz;
	logic [LEVELS_W-1:0] levels;

	// Address decode of the latched word
	assign ch_ext   = {{IDX_W{1'b0}}, cmd_q.channel};
	assign ch_sext  = {{SIDX_W{1'b0}}, cmd_q.channel};
	assign ch_idx   = ch_ext[IDX_W-1:0];
	assign ch_s     = ch_sext[SIDX_W-1:0];
	assign in_range = 32'(cmd_q.channel) < 32'(CHANNELS);
	assign ws       = idx_q[SIDX_W-1:0];
	assign slot_ext = {4'b0000, idx_q};

	// Phase check of the channel under the walk pointer
	assign elapsed = tick_q - phase_q[ws];
	assign len_sel = lvl_q[ws] ? hi_len_q[ws] : lo_len_q[ws];
	assign toggle  = in_use_q[idx_q] && run_q[ws] && (elapsed > TICK_W'(len_sel));

	// Period division by the requested frequency
	assign div_go       = ctl.div1_go;
	assign per_new      = div_quo[LEN_W-1:0];
	assign div_dividend = DIV_W'(TICK_RATE_HZ);
	assign div_divisor  = cmd_q.frequency;

	mctp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// High time = period * duty / 100; low time is the period less the high time rounded up
	assign recip_prod = RPROD_W'(prod_s1[PROD_W-1:2]) * RPROD_W'(RECIP_25);
	assign prod_back  = PROD_W'(hi_s2) * PROD_W'(DUTY_MAX);
	assign rem_nz     = prod_back != prod_s2;

	// Status towards the controller
	always_comb begin
		sts            = '0;
		sts.op_tick    = cmd_q.operation == OP_TICK;
		sts.op_alloc   = cmd_q.operation == OP_ALLOCATE;
		sts.op_rel     = cmd_q.operation == OP_RELEASE;
		sts.op_start   = cmd_q.operation == OP_START;
		sts.op_stop    = cmd_q.operation == OP_STOP;
		sts.start_ok   = in_range && in_use_q[ch_idx] && (cmd_q.frequency != '0) &&
		                 (32'(cmd_q.frequency) < 32'(HALF_RATE)) &&
		                 (cmd_q.duty_percent <= 7'(DUTY_MAX));
		sts.walk_last  = idx_q == IDX_W'(NSTORE - 1);
		sts.alloc_free = !in_use_q[idx_q];
		sts.alloc_last = idx_q == IDX_W'(CHANNELS - 1);
		sts.div_done   = div_done || mv_s3;
	end

	// Gather the pin levels; absent channels read low
	always_comb begin
		levels = '0;
		for (int i = 0; i < NSTORE; i++) begin
			levels[i] = lvl_q[i];
		end
	end

	// Control and reset-cleared channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			in_use_q <= '0;
			run_q    <= '0;
			lvl_q    <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
			mv_s1    <= 1'b0;
			mv_s2    <= 1'b0;
			mv_s3    <= 1'b0;
		end else begin
			done_q <= ctl.finish;
			// Advance the high/low time stages
			mv_s1  <= ctl.div2_go;
			mv_s2  <= mv_s1;
			mv_s3  <= mv_s2;
			if (ctl.load) begin
				idx_q <= '0;
			end
			if (ctl.tick_inc) begin
				tick_q <= tick_q + TICK_W'(1);
			end
			// Walk one channel per cycle
			if (ctl.walk_step) begin
				if (toggle) begin
					lvl_q[ws] <= !lvl_q[ws];
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			// Scan for the lowest free slot
			if (ctl.alloc_step) begin
				if (!in_use_q[idx_q]) begin
					in_use_q[idx_q] <= 1'b1;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (ctl.rel_do && in_range) begin
				in_use_q[ch_idx] <= 1'b0;
			end
			if (ctl.stop_do && in_range && in_use_q[ch_idx]) begin
				run_q[ch_s] <= 1'b0;
				lvl_q[ch_s] <= cmd_q.pin_level;
			end
			if (ctl.commit) begin
				run_q[ch_s] <= 1'b1;
				lvl_q[ch_s] <= cmd_q.pin_level;
			end
		end
	end

	// Payload: command word, timing stores, result fields
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			ok_q   <= 1'b0;
			slot_q <= NO_SLOT;
		end
		if (ctl.tick_inc) begin
			ok_q <= 1'b1;
		end
		if (ctl.walk_step && toggle) begin
			phase_q[ws] <= tick_q;
		end
		if (ctl.alloc_step && !in_use_q[idx_q]) begin
			ok_q   <= 1'b1;
			slot_q <= signed'(slot_ext[3:0]);
		end
		if (ctl.rel_do && in_range) begin
			ok_q <= 1'b1;
		end
		if (ctl.stop_do && in_range && in_use_q[ch_idx]) begin
			ok_q <= 1'b1;
		end
		if (ctl.div1_take) begin
			per_q <= per_new;
		end
		// Product, then quotient by 100, then low time
		if (ctl.div2_go) begin
			prod_s1 <= PROD_W'(per_new) * PROD_W'(cmd_q.duty_percent);
		end
		if (mv_s1) begin
			prod_s2 <= prod_s1;
			hi_s2   <= recip_prod[RECIP_SH +: LEN_W];
		end
		if (mv_s2) begin
			hi_s3 <= hi_s2;
			lo_s3 <= per_q - hi_s2 - LEN_W'(rem_nz);
		end
		if (ctl.commit) begin
			hi_len_q[ch_s] <= hi_s3;
			lo_len_q[ch_s] <= lo_s3;
			phase_q[ch_s]  <= tick_q;
			ok_q           <= 1'b1;
		end
		if (ctl.finish) begin
			rsp_q.pin_levels     <= levels;
			rsp_q.allocated_slot <= slot_q;
			rsp_q.accepted       <= ok_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[sv/mctp_ctrl.sv]
// Controller: sequences each command word through the datapath.
module mctp_ctrl
	import mctp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DISPATCH = 7'b0000010,
		ST_WALK     = 7'b0000100,
		ST_ALLOC    = 7'b0001000,
		ST_DIV1     = 7'b0010000,
		ST_DIV2     = 7'b0100000,
		ST_FINISH   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (sts.op_tick) begin
					ctl.tick_inc = 1'b1;
					state_d      = ST_WALK;
				end else if (sts.op_alloc) begin
					state_d = ST_ALLOC;
				end else if (sts.op_rel) begin
					ctl.rel_do = 1'b1;
					state_d    = ST_FINISH;
				end else if (sts.op_stop) begin
					ctl.stop_do = 1'b1;
					state_d     = ST_FINISH;
				end else if (sts.op_start && sts.start_ok) begin
					ctl.div1_go = 1'b1;
					state_d     = ST_DIV1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_WALK: begin
				ctl.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_ALLOC: begin
				ctl.alloc_step = 1'b1;
				if (sts.alloc_free || sts.alloc_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					ctl.div1_take = 1'b1;
					ctl.div2_go   = 1'b1;
					state_d       = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					ctl.commit = 1'b1;
					state_d    = ST_FINISH;
				end
			end
			ST_FINISH: begin
				ctl.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

[sv/multi_channel_tick_pwm_unit.sv]
// Multi-channel tick PWM unit: top level joining controller and datapath.
// One word at a time. Tick: walks the min(CHANNELS,8) stored channels, one channel per cycle, then strobes done.
// Allocate: scans the slots from the lowest for a free one. Release, stop, rejected start: go straight to finish.
// Start: runs the bit-serial period divider, then the three high/low time stages.
// busy is low again when done strobes, so a new word may follow at once; done cannot be held off.
// arst_n clears the tick count, slot, running and level flags; timing stores are not cleared.
module multi_channel_tick_pwm_unit
	import mctp_pkg::*;
#(
	parameter int CHANNELS     = CHANNELS_DEF,
	parameter int TICK_RATE_HZ = TICK_RATE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  cmd,
	output logic      done,
	output out_word_t rsp
);

	ctl_t ctl;
	sts_t sts;

	mctp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	mctp_dp #(
		.CHANNELS     (CHANNELS),
		.TICK_RATE_HZ (TICK_RATE_HZ)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
